// ===== sv/e2q_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler-to-quaternion block.
// Used by e2q_cordic_cell, e2q_quat_mult and euler_to_quaternion; depends on nothing.
`default_nettype none

package e2q_pkg;

  // Field widths of the angle and quaternion words.
  localparam int ANGLE_BITS = 16;
  localparam int QUAT_BITS  = 16;

  // Default and upper bound for the number of CORDIC cells.
  localparam int TRIG_STAGES     = 16;
  localparam int TRIG_MAX_STAGES = 32;

  // CORDIC datapath: x and y in Q.30, angle accumulator with a full circle of 2^32.
  localparam int CORDIC_FRAC = 30;
  localparam int CW          = 32;
  localparam int ZW          = 34;
  localparam int SUM_W       = CW + 2;
  localparam int ANG_SHIFT   = 32 - ANGLE_BITS;

  localparam logic signed [CW-1:0] CORDIC_XINIT = CW'(652032874);

  // Twice atan(2^-i) in accumulator units.
  localparam logic signed [ZW-1:0] ATAN2_TAB [TRIG_MAX_STAGES] = '{
    ZW'(1073741824), ZW'(633866812), ZW'(334917814), ZW'(170009512),
    ZW'(85334662),   ZW'(42708930),  ZW'(21359676),  ZW'(10680490),
    ZW'(5340326),    ZW'(2670174),   ZW'(1335088),   ZW'(667544),
    ZW'(333772),     ZW'(166886),    ZW'(83444),     ZW'(41722),
    ZW'(20860),      ZW'(10430),     ZW'(5216),      ZW'(2608),
    ZW'(1304),       ZW'(652),       ZW'(326),       ZW'(162),
    ZW'(82),         ZW'(40),        ZW'(20),        ZW'(10),
    ZW'(6),          ZW'(2),         ZW'(2),         ZW'(0)
  };

  // Output rounding: shift down to QUAT_BITS-1 fraction bits, or up when wider.
  localparam int RND_W   = SUM_W + 2;
  localparam int RND_SH  = (QUAT_BITS - 1 <= CORDIC_FRAC) ? CORDIC_FRAC - (QUAT_BITS - 1) : 0;
  localparam int UP_SH   = (QUAT_BITS - 1 > CORDIC_FRAC) ? (QUAT_BITS - 1) - CORDIC_FRAC : 0;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'((64'sd1 <<< RND_SH) >>> 1);
  localparam logic signed [RND_W-1:0] Q_HI = RND_W'((64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] Q_LO = -Q_HI - RND_W'(1);

  // Input word: one angle triple.
  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angles_t;

  // Result word: one unit quaternion.
  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } quat_t;

  // One rotation lane of the CORDIC chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } trig_lane_t;

  // Word handed from cell to cell: lane 0 roll, lane 1 pitch, lane 2 yaw.
  typedef struct packed {
    logic                valid;
    trig_lane_t [2:0]    lane;
  } trig_word_t;

  // Q.30 product, floored back to Q.30 (bits above CW are dropped, not saturated).
  function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return p[CW+CORDIC_FRAC-1:CORDIC_FRAC];
  endfunction

  // Round half up to the output format and saturate.
  function automatic logic signed [QUAT_BITS-1:0] round_sat(
      input logic signed [SUM_W-1:0] v);
    logic signed [RND_W-1:0] r;
    r = ((RND_W'(v) + RND_HALF) >>> RND_SH) <<< UP_SH;
    if (r > Q_HI) begin
      r = Q_HI;
    end else if (r < Q_LO) begin
      r = Q_LO;
    end
    return r[QUAT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/e2q_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed micro-rotation on three lanes, registered.
// Depends on e2q_pkg for the lane types and the arctangent table.
`default_nettype none

module e2q_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire e2q_pkg::trig_word_t in_w,
  output e2q_pkg::trig_word_t      out_w
);

  e2q_pkg::trig_word_t word_nxt;
  e2q_pkg::trig_word_t word_r;

  // Rotate each lane toward a zero residual angle.
  always_comb begin
    logic signed [e2q_pkg::CW-1:0] dx;
    logic signed [e2q_pkg::CW-1:0] dy;
    word_nxt       = in_w;
    for (int l = 0; l < 3; l++) begin
      dx = $signed(in_w.lane[l].y) >>> STAGE;
      dy = $signed(in_w.lane[l].x) >>> STAGE;
      if (!in_w.lane[l].z[e2q_pkg::ZW-1]) begin
        word_nxt.lane[l].x = $signed(in_w.lane[l].x) - dx;
        word_nxt.lane[l].y = $signed(in_w.lane[l].y) + dy;
        word_nxt.lane[l].z = $signed(in_w.lane[l].z) - e2q_pkg::ATAN2_TAB[STAGE];
      end else begin
        word_nxt.lane[l].x = $signed(in_w.lane[l].x) + dx;
        word_nxt.lane[l].y = $signed(in_w.lane[l].y) - dy;
        word_nxt.lane[l].z = $signed(in_w.lane[l].z) + e2q_pkg::ATAN2_TAB[STAGE];
      end
    end
  end

  // Hand the word to the next cell; reset clears the whole word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign out_w = word_r;

endmodule

`default_nettype wire

// ===== sv/e2q_quat_mult.sv =====
// Quaternion assembly: pair products, triple products, then sum, round and saturate.
// Depends on e2q_pkg for the word types and the fixed-point helpers.
`default_nettype none

module e2q_quat_mult (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire e2q_pkg::trig_word_t in_w,
  output logic                     out_valid,
  output e2q_pkg::quat_t           out_quat
);

  localparam int CW = e2q_pkg::CW;

  logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;

  logic                 valid1_r;
  logic signed [CW-1:0] cc_r, ss_r, sc_r, cs_r, cy_r, sy_r;

  logic                 valid2_r;
  logic signed [CW-1:0] w1_r, w2_r, x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;

  logic                 valid3_r;
  e2q_pkg::quat_t       quat_r;

  // Lane outputs: y is the sine and x the cosine of the half angle.
  assign sr = in_w.lane[0].y;
  assign cr = in_w.lane[0].x;
  assign sp = in_w.lane[1].y;
  assign cp = in_w.lane[1].x;
  assign sy = in_w.lane[2].y;
  assign cy = in_w.lane[2].x;

  // Stage one: roll-pitch pair products, yaw terms carried along.
  always_ff @(posedge clk) begin
    cc_r <= e2q_pkg::mul_q30(cr, cp);
    ss_r <= e2q_pkg::mul_q30(sr, sp);
    sc_r <= e2q_pkg::mul_q30(sr, cp);
    cs_r <= e2q_pkg::mul_q30(cr, sp);
    cy_r <= cy;
    sy_r <= sy;
  end

  // Stage two: the eight triple products.
  always_ff @(posedge clk) begin
    w1_r <= e2q_pkg::mul_q30(cc_r, cy_r);
    w2_r <= e2q_pkg::mul_q30(ss_r, sy_r);
    x1_r <= e2q_pkg::mul_q30(sc_r, cy_r);
    x2_r <= e2q_pkg::mul_q30(cs_r, sy_r);
    y1_r <= e2q_pkg::mul_q30(cs_r, cy_r);
    y2_r <= e2q_pkg::mul_q30(sc_r, sy_r);
    z1_r <= e2q_pkg::mul_q30(cc_r, sy_r);
    z2_r <= e2q_pkg::mul_q30(ss_r, cy_r);
  end

  // Stage three: combine, round and saturate into the output register.
  always_ff @(posedge clk) begin
    quat_r.quat_w <= e2q_pkg::round_sat(e2q_pkg::SUM_W'(w1_r) + e2q_pkg::SUM_W'(w2_r));
    quat_r.quat_x <= e2q_pkg::round_sat(e2q_pkg::SUM_W'(x1_r) - e2q_pkg::SUM_W'(x2_r));
    quat_r.quat_y <= e2q_pkg::round_sat(e2q_pkg::SUM_W'(y1_r) + e2q_pkg::SUM_W'(y2_r));
    quat_r.quat_z <= e2q_pkg::round_sat(e2q_pkg::SUM_W'(z1_r) - e2q_pkg::SUM_W'(z2_r));
  end

  // Valid bits follow the data through the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid1_r <= in_w.valid;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r;
    end
  end

  assign out_valid = valid3_r;
  assign out_quat  = quat_r;

endmodule

`default_nettype wire

// ===== sv/euler_to_quaternion.sv =====
// Top level: Euler angles (ZYX) to unit quaternion through a chain of CORDIC cells.
// Depends on e2q_pkg, e2q_cordic_cell and e2q_quat_mult.
//
//   channel   ports                      direction   handshake
//   input     start, busy, in_angles     in          taken when start and not busy
//   result    out_valid, out_quat        out         one-cycle strobe, cannot be held
//
// One word enters every cycle that start is high and busy is low; busy is high only
// during reset and the cycle after it. A taken word passes one register per CORDIC
// cell (TRIG_STAGES, capped at 32), then the pair products, triple products and the
// round/saturate register before its result is strobed.
// Reset clears the valid bits of the cells and of the product stages, dropping
// words in flight. There is no back-pressure on the result side.
`default_nettype none

module euler_to_quaternion #(
  parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire e2q_pkg::angles_t in_angles,
  output logic                  out_valid,
  output e2q_pkg::quat_t        out_quat
);

  localparam int NSTG = (TRIG_STAGES > e2q_pkg::TRIG_MAX_STAGES) ?
                        e2q_pkg::TRIG_MAX_STAGES : TRIG_STAGES;
  localparam int LAT  = NSTG + 3;

  logic                busy_r;
  logic                accept;
  e2q_pkg::trig_word_t chain [NSTG+1];

  // Hold off the input during reset and the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Load the chain: x at 1/K, y at zero, z the angle in 2^32-per-circle units.
  always_comb begin
    chain[0].valid = accept;
    for (int l = 0; l < 3; l++) begin
      chain[0].lane[l].x = e2q_pkg::CORDIC_XINIT;
      chain[0].lane[l].y = '0;
    end
    chain[0].lane[0].z = e2q_pkg::ZW'($signed(in_angles.roll_angle)) <<< e2q_pkg::ANG_SHIFT;
    chain[0].lane[1].z = e2q_pkg::ZW'($signed(in_angles.pitch_angle)) <<< e2q_pkg::ANG_SHIFT;
    chain[0].lane[2].z = e2q_pkg::ZW'($signed(in_angles.yaw_angle)) <<< e2q_pkg::ANG_SHIFT;
  end

  // Row of rotation cells, one micro-rotation each.
  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    e2q_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .in_w  (chain[i]),
      .out_w (chain[i+1])
    );
  end

  // Product and rounding pipeline.
  e2q_quat_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_w      (chain[NSTG]),
    .out_valid (out_valid),
    .out_quat  (out_quat)
  );

  // Every taken word produces a result strobe.
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted word did not produce a result on time");

  // No result strobe without a matching taken word.
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted word");

  // A taken word enters the first cell on the next edge.
  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> chain[1].valid)
    else $error("accepted word missing from the first cell");

endmodule

`default_nettype wire

// ===== tb/euler_to_quaternion_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for euler_to_quaternion: drives angle triples and checks quaternions.
// Depends on e2q_pkg for the word types and widths; predicts results with its own CORDIC model.

// Predicts the quaternion of each accepted angle word and checks returned words in order.
class quat_scoreboard;
  localparam int     AB       = e2q_pkg::ANGLE_BITS;
  localparam int     QB       = e2q_pkg::QUAT_BITS;
  localparam int     FRAC     = 30;
  localparam int     MAX_CELLS = 32;
  localparam longint TRIG_X0  = 652032874;

  // Twice atan(2^-i), full circle = 2^32.
  longint           twice_atan [MAX_CELLS];
  e2q_pkg::quat_t   expected_quats [$];
  int               errors;
  int               checked;
  int               noted;

  function new();
    twice_atan = '{
      1073741824, 633866812, 334917814, 170009512, 85334662, 42708930, 21359676, 10680490,
      5340326, 2670174, 1335088, 667544, 333772, 166886, 83444, 41722,
      20860, 10430, 5216, 2608, 1304, 652, 326, 162,
      82, 40, 20, 10, 6, 2, 2, 0
    };
    errors  = 0;
    checked = 0;
    noted   = 0;
  endfunction

  // Rotation-mode CORDIC on the half angle; the accumulator holds twice the residual.
  function void half_sincos(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    int     cells;
    x = TRIG_X0;
    y = 0;
    z = ang * (longint'(1) << (32 - AB));
    cells = (e2q_pkg::TRIG_STAGES > MAX_CELLS) ? MAX_CELLS : e2q_pkg::TRIG_STAGES;
    for (int i = 0; i < cells; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - twice_atan[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + twice_atan[i];
      end
    end
    s = y;
    c = x;
  endfunction

  // Triple product in Q.30, floored after each multiply.
  function longint prod3(longint a, longint b, longint c);
    longint p;
    p = (a * b) >>> FRAC;
    return (p * c) >>> FRAC;
  endfunction

  // Round half up to the output fraction width, then saturate.
  function logic signed [QB-1:0] to_quat(longint v);
    longint hi, lo, r;
    int     sh;
    hi = (longint'(1) << (QB - 1)) - 1;
    lo = -hi - 1;
    sh = FRAC - (QB - 1);
    if (sh > 0) begin
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
    end else if (sh == 0) begin
      r = v;
    end else begin
      r = v <<< (-sh);
    end
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[QB-1:0];
  endfunction

  // ZYX composition of the three half-angle rotations.
  function e2q_pkg::quat_t quat_from_euler(e2q_pkg::angles_t a);
    longint         sr, cr, sp, cp, sy, cy;
    e2q_pkg::quat_t q;
    half_sincos(longint'(a.roll_angle), sr, cr);
    half_sincos(longint'(a.pitch_angle), sp, cp);
    half_sincos(longint'(a.yaw_angle), sy, cy);
    q.quat_w = to_quat(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.quat_x = to_quat(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.quat_y = to_quat(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.quat_z = to_quat(prod3(cr, cp, sy) - prod3(sr, sp, cy));
    return q;
  endfunction

  function void note_angles(e2q_pkg::angles_t a);
    expected_quats.push_back(quat_from_euler(a));
    noted++;
  endfunction

  function int pending();
    return expected_quats.size();
  endfunction

  function void compare_field(string name, logic signed [QB-1:0] want,
                              logic signed [QB-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Every strobed word must match the oldest outstanding prediction.
  function void check_quat(e2q_pkg::quat_t got);
    e2q_pkg::quat_t want;
    if (expected_quats.size() == 0) begin
      errors++;
      $display("%0t: unexpected quaternion word, expected none, actual %h", $time, got);
      return;
    end
    want = expected_quats.pop_front();
    checked++;
    compare_field("quat_w", want.quat_w, got.quat_w);
    compare_field("quat_x", want.quat_x, got.quat_x);
    compare_field("quat_y", want.quat_y, got.quat_y);
    compare_field("quat_z", want.quat_z, got.quat_z);
  endfunction
endclass

module euler_to_quaternion_test;
  localparam int AB      = e2q_pkg::ANGLE_BITS;
  localparam int LATENCY = e2q_pkg::TRIG_STAGES + 3;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  e2q_pkg::angles_t in_angles;
  logic             out_valid;
  e2q_pkg::quat_t   out_quat;

  quat_scoreboard   quat_board;
  int               directed_count;

  euler_to_quaternion i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_angles (in_angles),
    .out_valid (out_valid),
    .out_quat  (out_quat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops words.
  initial begin
    #(3_000_000);
    $display("euler_to_quaternion_test failed");
    $finish;
  end

  // Result side: the strobe cannot be held off, so every strobed word is checked here.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      quat_board.check_quat(out_quat);
    end
  end

  function automatic e2q_pkg::angles_t triple(int roll, int pitch, int yaw);
    e2q_pkg::angles_t a;
    a.roll_angle  = AB'(roll);
    a.pitch_angle = AB'(pitch);
    a.yaw_angle   = AB'(yaw);
    return a;
  endfunction

  // Mostly uniform angles, with corners and near-zero values mixed in.
  function automatic logic signed [AB-1:0] random_angle();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return AB'(-32768);
          1: return AB'(32767);
          2: return AB'(16384);
          3: return AB'(-16384);
          4: return AB'(0);
          default: return AB'(-1);
        endcase
      end
      1: return AB'(int'($urandom_range(0, 32)) - 16);
      default: return AB'($urandom);
    endcase
  endfunction

  // Offer one word, idling first with the given chance per cycle; returns once it is taken.
  task automatic send_angles(e2q_pkg::angles_t a, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start     = 1'b1;
    in_angles = a;
    do @(posedge clk); while (busy !== 1'b0);
    quat_board.note_angles(a);
  endtask

  // Hold the sender off until every outstanding word has come back.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (quat_board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_directed(int idle_pct);
    e2q_pkg::angles_t list [$];
    list = '{
      triple(0, 0, 0),             triple(-32768, 0, 0),      triple(0, -32768, 0),
      triple(0, 0, -32768),        triple(-32768, -32768, -32768),
      triple(32767, 32767, 32767), triple(32767, 0, 0),       triple(0, 32767, 0),
      triple(0, 0, 32767),         triple(16384, 0, 0),       triple(0, 16384, 0),
      triple(0, 0, 16384),         triple(16384, 16384, 16384),
      triple(-16384, -16384, -16384), triple(-1, -1, -1),     triple(1, 1, 1),
      triple(-32768, 32767, -32768), triple(21845, -21846, 21845),
      triple(-21846, 21845, -21846), triple(8192, -8192, 24576), triple(-32768, 16384, 0)
    };
    foreach (list[i]) send_angles(list[i], idle_pct);
    directed_count = list.size();
  endtask

  initial begin
    int idle_pct [3];
    int burst    [3];
    quat_board = new();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_angles  = '0;
    idle_pct   = '{35, 76, 0};
    burst      = '{345, 345, 340};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Corners and the half-angle of minus pi first, then random words per idling phase.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) send_directed(idle_pct[ph]);
      for (int n = 0; n < burst[ph]; n++) begin
        send_angles({random_angle(), random_angle(), random_angle()}, idle_pct[ph]);
      end
      drain_results();
    end

    // Let any stray word surface before judging.
    repeat (LATENCY + 8) @(posedge clk);
    $display("Sent %0d angle words (%0d directed) over sparse, heavy and back-to-back input.",
             quat_board.noted, directed_count);
    $display("Checked %0d quaternion words, %0d errors, %0d still outstanding.",
             quat_board.checked, quat_board.errors, quat_board.pending());
    if (quat_board.errors == 0 && quat_board.pending() == 0) begin
      $display("euler_to_quaternion_test passed");
    end else begin
      $display("euler_to_quaternion_test failed");
    end
    $finish;
  end
endmodule
